### hdl/gillespie_two_species_step_core_macros.svh
// Assertion macros shared by the checker of the Gillespie step core.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef GILLESPIE_TWO_SPECIES_STEP_CORE_MACROS_SVH
`define GILLESPIE_TWO_SPECIES_STEP_CORE_MACROS_SVH

// same-cycle implication
`define GTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gts assertion failed");

// next-cycle implication
`define GTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gts assertion failed");

`endif

### hdl/gts_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and command/status types of the Gillespie step core.
// No dependencies.
package gts_pkg;

    localparam int COUNT_BITS         = 16;
    localparam int RATE_W             = 32;
    localparam int RAND_W             = 32;
    localparam int PROP_W             = 48;
    localparam int TOTAL_W            = 51;
    localparam int TARGET_W           = 52;
    localparam int TIME_W             = 48;
    localparam int DIV_W              = 64;
    localparam int MUL_W              = 32;
    localparam int LOG_FRAC           = 24;
    localparam int LG_W               = 29;
    localparam int NUM_REACT          = 6;
    localparam int PICK_IDX_W         = 3;
    localparam int IDX_W              = 5;
    localparam int OP_W               = 5;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 32;
    localparam int POP_SCALE_DEF      = 1000;
    localparam int TIME_FRAC_BITS_DEF = 24;

    localparam logic [MUL_W-1:0]      LN2_Q32    = 32'd2977044472;
    localparam logic [PROP_W-1:0]     PROP_MAX   = {PROP_W{1'b1}};
    localparam logic [TIME_W-1:0]     TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [RATE_W-1:0]     RATE_RST   = 32'd65536;
    localparam logic [COUNT_BITS-1:0] START_RST  = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KAPPA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_B = 3'd5;

    // reaction codes reported on fired
    localparam logic [2:0] FIRED_NONE = 3'd0;
    localparam logic [2:0] RX_A_DECAY = 3'd1;
    localparam logic [2:0] RX_A_PAIR  = 3'd2;
    localparam logic [2:0] RX_B_DECAY = 3'd3;
    localparam logic [2:0] RX_B_PAIR  = 3'd4;
    localparam logic [2:0] RX_B_GROW  = 3'd5;
    localparam logic [2:0] RX_A_GROW  = 3'd6;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
    localparam logic [OP_W-1:0] OP_MUL_AB    = 5'd2;
    localparam logic [OP_W-1:0] OP_MUL_W1    = 5'd3;
    localparam logic [OP_W-1:0] OP_MUL_W3    = 5'd4;
    localparam logic [OP_W-1:0] OP_MUL_W5    = 5'd5;
    localparam logic [OP_W-1:0] OP_MUL_KAB   = 5'd6;
    localparam logic [OP_W-1:0] OP_DIV_P     = 5'd7;
    localparam logic [OP_W-1:0] OP_STORE_W6  = 5'd8;
    localparam logic [OP_W-1:0] OP_MUL_AW6LO = 5'd9;
    localparam logic [OP_W-1:0] OP_MUL_AW6HI = 5'd10;
    localparam logic [OP_W-1:0] OP_STORE_W2  = 5'd11;
    localparam logic [OP_W-1:0] OP_MUL_OAB   = 5'd12;
    localparam logic [OP_W-1:0] OP_STORE_W4  = 5'd13;
    localparam logic [OP_W-1:0] OP_MUL_TLO   = 5'd14;
    localparam logic [OP_W-1:0] OP_MUL_THI   = 5'd15;
    localparam logic [OP_W-1:0] OP_PICK      = 5'd16;
    localparam logic [OP_W-1:0] OP_LOG_INIT  = 5'd17;
    localparam logic [OP_W-1:0] OP_LOG_SQ    = 5'd18;
    localparam logic [OP_W-1:0] OP_LOG_LN    = 5'd19;
    localparam logic [OP_W-1:0] OP_DIV_TAU   = 5'd20;
    localparam logic [OP_W-1:0] OP_STORE_TAU = 5'd21;
    localparam logic [OP_W-1:0] OP_FINISH    = 5'd22;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
    } gts_cmd_t;

    typedef struct packed {
        logic action;
        logic zero_total;
        logic div_done;
    } gts_sts_t;

endpackage

### hdl/gillespie_two_species_step_core.sv
`timescale 1ns / 1ps
// Two-species Gillespie direct-method step: one request in, one result out.
// A step runs a bit-serial divide by the total, 3 digit-wise divides by the
// population scale, multiplies, 24 log squarings and control. A restart request
// skips them and goes straight to the result update.
// One request in flight at a time. Reset: counts and time zero, rates 1.0, starts 1000.
module gillespie_two_species_step_core
    import gts_pkg::*;
#(
    parameter int TIME_FRAC_BITS = gts_pkg::TIME_FRAC_BITS_DEF,
    parameter int POP_SCALE      = gts_pkg::POP_SCALE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gts_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic [gts_pkg::RAND_W-1:0]         rand_time,
    input  logic [gts_pkg::RAND_W-1:0]         rand_pick,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [gts_pkg::TIME_W-1:0]         sim_time,
    output logic [gts_pkg::COUNT_BITS-1:0]     count_a,
    output logic [gts_pkg::COUNT_BITS-1:0]     count_b,
    output logic [2:0]                         fired,
    output logic                               extinct
);
    gts_cmd_t cmd;
    gts_sts_t sts;

    gts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    gts_dp #(
        .TIME_FRAC_BITS (TIME_FRAC_BITS),
        .POP_SCALE      (POP_SCALE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .action    (action),
        .rand_time (rand_time),
        .rand_pick (rand_pick),
        .cmd       (cmd),
        .sts       (sts),
        .sim_time  (sim_time),
        .count_a   (count_a),
        .count_b   (count_b),
        .fired     (fired),
        .extinct   (extinct)
    );
endmodule

### hdl/gts_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the datapath of the Gillespie step core.
module gts_div #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quot,
    output logic         done
);
    localparam int CNT_W = $clog2(W + 1);

    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [W:0]       shifted;
    logic             ge;

    always_comb
    begin
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        ge        = shifted >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            den_next = den;
            cnt_next = CNT_W'(W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? (shifted - {1'b0, den_reg}) : shifted;
            quo_next  = {quo_reg[W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quot = quo_reg;
    assign done = done_reg;
endmodule

### hdl/gts_dp.sv
`timescale 1ns / 1ps
// Datapath of the Gillespie step core: config registers, species state, one shared
// 32x32 multiplier (also used by the reciprocal divide by the population scale)
// and the bit-serial divider for the time step. Uses gts_pkg, gts_div.
module gts_dp #(
    parameter int TIME_FRAC_BITS = gts_pkg::TIME_FRAC_BITS_DEF,
    parameter int POP_SCALE      = gts_pkg::POP_SCALE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gts_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               action,
    input  logic [gts_pkg::RAND_W-1:0]         rand_time,
    input  logic [gts_pkg::RAND_W-1:0]         rand_pick,
    input  gts_pkg::gts_cmd_t                  cmd,
    output gts_pkg::gts_sts_t                  sts,
    output logic [gts_pkg::TIME_W-1:0]         sim_time,
    output logic [gts_pkg::COUNT_BITS-1:0]     count_a,
    output logic [gts_pkg::COUNT_BITS-1:0]     count_b,
    output logic [2:0]                         fired,
    output logic                               extinct
);
    import gts_pkg::*;

    // divide by the population scale: 16-bit digits, reciprocal estimate, then fix-up
    localparam int         PS_W      = 16;
    localparam int         PD_CHUNKS = DIV_W / PS_W;
    localparam logic [1:0] PD_RECIP  = 2'd0;
    localparam logic [1:0] PD_BACK   = 2'd1;
    localparam logic [1:0] PD_FIX    = 2'd2;
    localparam logic [MUL_W-1:0] POP_ONE   = MUL_W'(POP_SCALE);
    localparam logic [MUL_W-1:0] POP_TWO   = MUL_W'(2 * POP_SCALE);
    localparam logic [MUL_W-1:0] POP_RECIP = MUL_W'(64'hFFFF_FFFF / 64'(POP_SCALE));

    // config
    logic [RATE_W-1:0]     kappa_reg, omega_reg, gamma_reg, sigma_reg;
    logic [COUNT_BITS-1:0] start_a_reg, start_b_reg;

    // architectural state
    logic [TIME_W-1:0]     elapsed_reg, elapsed_next;
    logic [COUNT_BITS-1:0] a_reg, a_next, b_reg, b_next;
    logic [2:0]            fired_reg, fired_next;
    logic                  extinct_reg, extinct_next;

    // working registers
    logic                  act_reg, act_next;
    logic [RAND_W-1:0]     rt_reg, rt_next, rp_reg, rp_next;
    logic [MUL_W-1:0]      ab_reg, ab_next;
    logic [PROP_W-1:0]     w_reg [NUM_REACT];
    logic [PROP_W-1:0]     w_next [NUM_REACT];
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [DIV_W-1:0]      prod_reg, prod_next;
    logic [TARGET_W-1:0]   target_reg, target_next;
    logic [TOTAL_W-1:0]    acc_reg, acc_next;
    logic [2:0]            pick_reg, pick_next;
    logic [MUL_W-1:0]      m_reg, m_next;
    logic [LG_W-1:0]       lg_reg, lg_next;
    logic [MUL_W-1:0]      ln_reg, ln_next;
    logic [TIME_W:0]       tau_reg, tau_next;

    // population-scale divider
    logic [1:0]            pd_ph_reg, pd_ph_next;
    logic [2:0]            pd_cnt_reg, pd_cnt_next;
    logic                  pd_done_reg, pd_done_next;
    logic [DIV_W-1:0]      pd_num_reg, pd_num_next;
    logic [DIV_W-1:0]      pd_quo_reg, pd_quo_next;
    logic [PS_W-1:0]       pd_rem_reg, pd_rem_next;
    logic [PS_W-1:0]       pd_q_reg, pd_q_next;
    logic [MUL_W-1:0]      pd_x_reg, pd_x_next;
    logic [MUL_W-1:0]      pd_t_reg, pd_t_next;
    logic                  pd_busy;
    logic [MUL_W-1:0]      pd_x_cat;
    logic [MUL_W-1:0]      pd_r, pd_r_fix;
    logic [PS_W-1:0]       pd_q_fix;

    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [DIV_W-1:0]      mul_p;
    logic                  div_start, div_done;
    logic [DIV_W-1:0]      div_num, div_den, div_q;
    logic [PROP_W-1:0]     q_sat;
    logic [TOTAL_W-1:0]    acc_sum;
    logic [RAND_W-1:0]     x_val;
    logic [4:0]            lead;
    logic [LG_W:0]         l2_val;
    logic [TIME_W:0]       time_sum;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kappa_reg   <= RATE_RST;
            omega_reg   <= RATE_RST;
            gamma_reg   <= RATE_RST;
            sigma_reg   <= RATE_RST;
            start_a_reg <= START_RST;
            start_b_reg <= START_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KAPPA:   kappa_reg   <= cfg_data[RATE_W-1:0];
                CFG_OMEGA:   omega_reg   <= cfg_data[RATE_W-1:0];
                CFG_GAMMA:   gamma_reg   <= cfg_data[RATE_W-1:0];
                CFG_SIGMA:   sigma_reg   <= cfg_data[RATE_W-1:0];
                CFG_START_A: start_a_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_START_B: start_b_reg <= cfg_data[COUNT_BITS-1:0];
                default:     ;
            endcase
        end
    end

    assign pd_busy  = (pd_cnt_reg != '0);
    assign pd_x_cat = {pd_rem_reg, pd_num_reg[DIV_W-1:DIV_W-PS_W]};

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_AB:    begin mul_a = MUL_W'(a_reg); mul_b = MUL_W'(b_reg); end
            OP_MUL_W1:    begin mul_a = gamma_reg; mul_b = MUL_W'(a_reg); end
            OP_MUL_W3:    begin mul_a = sigma_reg; mul_b = MUL_W'(b_reg); end
            OP_MUL_W5:    begin mul_a = omega_reg; mul_b = MUL_W'(a_reg); end
            OP_MUL_KAB:   begin mul_a = kappa_reg; mul_b = ab_reg; end
            OP_MUL_AW6LO: begin mul_a = MUL_W'(a_reg); mul_b = w_reg[5][MUL_W-1:0]; end
            OP_MUL_AW6HI:
            begin
                mul_a = MUL_W'(a_reg);
                mul_b = MUL_W'(w_reg[5][PROP_W-1:MUL_W]);
            end
            OP_MUL_OAB:   begin mul_a = omega_reg; mul_b = ab_reg; end
            OP_MUL_TLO:   begin mul_a = total_reg[MUL_W-1:0]; mul_b = rp_reg; end
            OP_MUL_THI:
            begin
                mul_a = MUL_W'(total_reg[TOTAL_W-1:MUL_W]);
                mul_b = rp_reg;
            end
            OP_LOG_SQ:    begin mul_a = m_reg; mul_b = m_reg; end
            OP_LOG_LN:    begin mul_a = MUL_W'(l2_val); mul_b = LN2_Q32; end
            default:
            begin
                // the population-scale divide runs while the sequencer waits
                if (pd_busy && (pd_ph_reg == PD_RECIP))
                begin
                    mul_a = pd_x_cat;
                    mul_b = POP_RECIP;
                end
                else if (pd_busy && (pd_ph_reg == PD_BACK))
                begin
                    mul_a = MUL_W'(pd_q_reg);
                    mul_b = POP_ONE;
                end
            end
        endcase
    end

    assign mul_p = DIV_W'(mul_a) * DIV_W'(mul_b);

    // population-scale divide: per 16-bit digit the reciprocal estimate is at most
    // two short, so one compare-and-subtract step finishes the digit
    always_comb
    begin
        pd_r = pd_x_reg - pd_t_reg;
        if (pd_r >= POP_TWO)
        begin
            pd_q_fix = pd_q_reg + PS_W'(2);
            pd_r_fix = pd_r - POP_TWO;
        end
        else if (pd_r >= POP_ONE)
        begin
            pd_q_fix = pd_q_reg + PS_W'(1);
            pd_r_fix = pd_r - POP_ONE;
        end
        else
        begin
            pd_q_fix = pd_q_reg;
            pd_r_fix = pd_r;
        end
        pd_ph_next   = pd_ph_reg;
        pd_cnt_next  = pd_cnt_reg;
        pd_done_next = 1'b0;
        pd_num_next  = pd_num_reg;
        pd_quo_next  = pd_quo_reg;
        pd_rem_next  = pd_rem_reg;
        pd_q_next    = pd_q_reg;
        pd_x_next    = pd_x_reg;
        pd_t_next    = pd_t_reg;
        if (cmd.op == OP_DIV_P)
        begin
            pd_num_next = prod_reg;
            pd_quo_next = '0;
            pd_rem_next = '0;
            pd_cnt_next = 3'(PD_CHUNKS);
            pd_ph_next  = PD_RECIP;
        end
        else if (pd_busy)
        begin
            case (pd_ph_reg)
                PD_RECIP:
                begin
                    pd_x_next  = pd_x_cat;
                    pd_q_next  = mul_p[MUL_W+PS_W-1:MUL_W];
                    pd_ph_next = PD_BACK;
                end
                PD_BACK:
                begin
                    pd_t_next  = mul_p[MUL_W-1:0];
                    pd_ph_next = PD_FIX;
                end
                PD_FIX:
                begin
                    pd_quo_next  = {pd_quo_reg[DIV_W-PS_W-1:0], pd_q_fix};
                    pd_rem_next  = pd_r_fix[PS_W-1:0];
                    pd_num_next  = pd_num_reg << PS_W;
                    pd_cnt_next  = pd_cnt_reg - 1'b1;
                    pd_done_next = (pd_cnt_reg == 3'd1);
                    pd_ph_next   = PD_RECIP;
                end
                default: pd_ph_next = PD_RECIP;
            endcase
        end
    end

    // bit-serial divider: time step over the total
    assign div_start = (cmd.op == OP_DIV_TAU);
    assign div_num   = DIV_W'(ln_reg) << (TIME_FRAC_BITS - 8);
    assign div_den   = DIV_W'(total_reg);

    gts_div #(
        .W(DIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_q),
        .done  (div_done)
    );

    always_comb
    begin
        q_sat    = (pd_quo_reg > DIV_W'(PROP_MAX)) ? PROP_MAX : pd_quo_reg[PROP_W-1:0];
        acc_sum  = acc_reg + TOTAL_W'(w_reg[cmd.idx[PICK_IDX_W-1:0]]);
        x_val    = (rt_reg == '0) ? RAND_W'(1) : rt_reg;
        lead     = '0;
        for (int i = 0; i < RAND_W; i++)
        begin
            if (x_val[i])
                lead = 5'(i);
        end
        l2_val   = {1'b1, {LG_W{1'b0}}} - {1'b0, lg_reg};
        time_sum = {1'b0, elapsed_reg} + tau_reg;
    end

    always_comb
    begin
        elapsed_next = elapsed_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        fired_next   = fired_reg;
        extinct_next = extinct_reg;
        act_next     = act_reg;
        rt_next      = rt_reg;
        rp_next      = rp_reg;
        ab_next      = ab_reg;
        w_next       = w_reg;
        total_next   = total_reg;
        prod_next    = prod_reg;
        target_next  = target_reg;
        acc_next     = acc_reg;
        pick_next    = pick_reg;
        m_next       = m_reg;
        lg_next      = lg_reg;
        ln_next      = ln_reg;
        tau_next     = tau_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                act_next = action;
                rt_next  = rand_time;
                rp_next  = rand_pick;
            end
            OP_MUL_AB:  ab_next = mul_p[MUL_W-1:0];
            OP_MUL_W1:
            begin
                w_next[0]  = mul_p[PROP_W-1:0];
                total_next = TOTAL_W'(mul_p[PROP_W-1:0]);
            end
            OP_MUL_W3:
            begin
                w_next[2]  = mul_p[PROP_W-1:0];
                total_next = total_reg + TOTAL_W'(mul_p[PROP_W-1:0]);
            end
            OP_MUL_W5:
            begin
                w_next[4]  = mul_p[PROP_W-1:0];
                total_next = total_reg + TOTAL_W'(mul_p[PROP_W-1:0]);
            end
            OP_MUL_KAB, OP_MUL_OAB, OP_MUL_AW6LO, OP_MUL_TLO: prod_next = mul_p;
            OP_MUL_AW6HI: prod_next = prod_reg + (mul_p << MUL_W);
            OP_STORE_W6:
            begin
                w_next[5]  = q_sat;
                total_next = total_reg + TOTAL_W'(q_sat);
            end
            OP_STORE_W2:
            begin
                w_next[1]  = q_sat;
                total_next = total_reg + TOTAL_W'(q_sat);
            end
            OP_STORE_W4:
            begin
                w_next[3]  = q_sat;
                total_next = total_reg + TOTAL_W'(q_sat);
            end
            OP_MUL_THI:
            begin
                target_next = TARGET_W'(mul_p) + TARGET_W'(prod_reg[DIV_W-1:MUL_W]);
                acc_next    = '0;
                pick_next   = FIRED_NONE;
            end
            OP_PICK:
            begin
                acc_next = acc_sum;
                // first partial sum above the target wins
                if ((pick_reg == FIRED_NONE) && (TARGET_W'(acc_sum) > target_reg))
                    pick_next = cmd.idx[PICK_IDX_W-1:0] + 3'd1;
            end
            OP_LOG_INIT:
            begin
                m_next  = x_val << (5'd31 - lead);
                lg_next = {lead, {LOG_FRAC{1'b0}}};
            end
            OP_LOG_SQ:
            begin
                // mantissa squared in Q1.31; a carry past 2.0 yields one log bit
                if (mul_p[DIV_W-1])
                begin
                    m_next = mul_p[DIV_W-1:MUL_W];
                    lg_next[cmd.idx] = 1'b1;
                end
                else
                    m_next = mul_p[DIV_W-2:MUL_W-1];
            end
            OP_LOG_LN:  ln_next = mul_p[DIV_W-1:MUL_W];
            OP_STORE_TAU:
                tau_next = (div_q > DIV_W'(TIME_MAX)) ? {1'b0, TIME_MAX} : div_q[TIME_W:0];
            OP_FINISH:
            begin
                if (act_reg)
                begin
                    a_next       = start_a_reg;
                    b_next       = start_b_reg;
                    elapsed_next = '0;
                    fired_next   = FIRED_NONE;
                    extinct_next = 1'b0;
                end
                else if (total_reg == '0)
                begin
                    fired_next   = FIRED_NONE;
                    extinct_next = 1'b1;
                end
                else
                begin
                    fired_next   = pick_reg;
                    extinct_next = 1'b0;
                    elapsed_next = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
                    case (pick_reg)
                        RX_A_DECAY, RX_A_PAIR:
                            if (a_reg != '0) a_next = a_reg - 1'b1;
                        RX_B_DECAY, RX_B_PAIR:
                            if (b_reg != '0) b_next = b_reg - 1'b1;
                        RX_B_GROW:
                            if (b_reg != COUNT_MAX) b_next = b_reg + 1'b1;
                        RX_A_GROW:
                            if (a_reg != COUNT_MAX) a_next = a_reg + 1'b1;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            pd_cnt_reg  <= '0;
            pd_done_reg <= 1'b0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            pd_cnt_reg  <= pd_cnt_next;
            pd_done_reg <= pd_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fired_reg   <= fired_next;
        extinct_reg <= extinct_next;
        act_reg     <= act_next;
        rt_reg      <= rt_next;
        rp_reg      <= rp_next;
        ab_reg      <= ab_next;
        w_reg       <= w_next;
        total_reg   <= total_next;
        prod_reg    <= prod_next;
        target_reg  <= target_next;
        acc_reg     <= acc_next;
        pick_reg    <= pick_next;
        m_reg       <= m_next;
        lg_reg      <= lg_next;
        ln_reg      <= ln_next;
        tau_reg     <= tau_next;
        pd_ph_reg   <= pd_ph_next;
        pd_num_reg  <= pd_num_next;
        pd_quo_reg  <= pd_quo_next;
        pd_rem_reg  <= pd_rem_next;
        pd_q_reg    <= pd_q_next;
        pd_x_reg    <= pd_x_next;
        pd_t_reg    <= pd_t_next;
    end

    assign sts.action     = act_reg;
    assign sts.zero_total = (total_reg == '0);
    assign sts.div_done   = div_done || pd_done_reg;

    assign sim_time = elapsed_reg;
    assign count_a  = a_reg;
    assign count_b  = b_reg;
    assign fired    = fired_reg;
    assign extinct  = extinct_reg;
endmodule

### hdl/gts_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the Gillespie step core: walks the datapath through one step
// and owns the request handshakes. Uses gts_pkg.
module gts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output gts_pkg::gts_cmd_t cmd,
    input  gts_pkg::gts_sts_t sts
);
    import gts_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISPATCH = 5'd1;
    localparam logic [4:0] S_MUL_AB   = 5'd2;
    localparam logic [4:0] S_MUL_W1   = 5'd3;
    localparam logic [4:0] S_MUL_W3   = 5'd4;
    localparam logic [4:0] S_MUL_W5   = 5'd5;
    localparam logic [4:0] S_MUL_KAB  = 5'd6;
    localparam logic [4:0] S_DS_W6    = 5'd7;
    localparam logic [4:0] S_DW_W6    = 5'd8;
    localparam logic [4:0] S_AW6LO    = 5'd9;
    localparam logic [4:0] S_AW6HI    = 5'd10;
    localparam logic [4:0] S_DS_W2    = 5'd11;
    localparam logic [4:0] S_DW_W2    = 5'd12;
    localparam logic [4:0] S_MUL_OAB  = 5'd13;
    localparam logic [4:0] S_DS_W4    = 5'd14;
    localparam logic [4:0] S_DW_W4    = 5'd15;
    localparam logic [4:0] S_CHECK    = 5'd16;
    localparam logic [4:0] S_TLO      = 5'd17;
    localparam logic [4:0] S_THI      = 5'd18;
    localparam logic [4:0] S_PICK     = 5'd19;
    localparam logic [4:0] S_LOG_INIT = 5'd20;
    localparam logic [4:0] S_LOG_SQ   = 5'd21;
    localparam logic [4:0] S_LOG_LN   = 5'd22;
    localparam logic [4:0] S_DS_TAU   = 5'd23;
    localparam logic [4:0] S_DW_TAU   = 5'd24;
    localparam logic [4:0] S_FINISH   = 5'd25;

    logic [4:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && out_stall;
        cmd.op      = OP_NOP;
        cmd.idx     = cnt_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            S_DISPATCH: state_next = sts.action ? S_FINISH : S_MUL_AB;
            S_MUL_AB:   begin cmd.op = OP_MUL_AB;  state_next = S_MUL_W1;  end
            S_MUL_W1:   begin cmd.op = OP_MUL_W1;  state_next = S_MUL_W3;  end
            S_MUL_W3:   begin cmd.op = OP_MUL_W3;  state_next = S_MUL_W5;  end
            S_MUL_W5:   begin cmd.op = OP_MUL_W5;  state_next = S_MUL_KAB; end
            S_MUL_KAB:  begin cmd.op = OP_MUL_KAB; state_next = S_DS_W6;   end
            S_DS_W6:    begin cmd.op = OP_DIV_P;   state_next = S_DW_W6;   end
            S_DW_W6:
                if (sts.div_done)
                begin
                    cmd.op     = OP_STORE_W6;
                    state_next = S_AW6LO;
                end
            S_AW6LO:    begin cmd.op = OP_MUL_AW6LO; state_next = S_AW6HI; end
            S_AW6HI:    begin cmd.op = OP_MUL_AW6HI; state_next = S_DS_W2; end
            S_DS_W2:    begin cmd.op = OP_DIV_P;     state_next = S_DW_W2; end
            S_DW_W2:
                if (sts.div_done)
                begin
                    cmd.op     = OP_STORE_W2;
                    state_next = S_MUL_OAB;
                end
            S_MUL_OAB:  begin cmd.op = OP_MUL_OAB; state_next = S_DS_W4; end
            S_DS_W4:    begin cmd.op = OP_DIV_P;   state_next = S_DW_W4; end
            S_DW_W4:
                if (sts.div_done)
                begin
                    cmd.op     = OP_STORE_W4;
                    state_next = S_CHECK;
                end
            S_CHECK:    state_next = sts.zero_total ? S_FINISH : S_TLO;
            S_TLO:      begin cmd.op = OP_MUL_TLO; state_next = S_THI; end
            S_THI:
            begin
                cmd.op     = OP_MUL_THI;
                cnt_next   = '0;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.op = OP_PICK;
                if (cnt_reg == IDX_W'(NUM_REACT - 1))
                    state_next = S_LOG_INIT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_LOG_INIT:
            begin
                cmd.op     = OP_LOG_INIT;
                cnt_next   = IDX_W'(LOG_FRAC - 1);
                state_next = S_LOG_SQ;
            end
            S_LOG_SQ:
            begin
                cmd.op = OP_LOG_SQ;
                if (cnt_reg == '0)
                    state_next = S_LOG_LN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_LOG_LN:   begin cmd.op = OP_LOG_LN;  state_next = S_DS_TAU; end
            S_DS_TAU:   begin cmd.op = OP_DIV_TAU; state_next = S_DW_TAU; end
            S_DW_TAU:
                if (sts.div_done)
                begin
                    cmd.op     = OP_STORE_TAU;
                    state_next = S_FINISH;
                end
            S_FINISH:
                // state and result registers update only once the output slot is free
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.op      = OP_FINISH;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
endmodule

### hdl/gts_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the Gillespie step core, bound to the top level.
// Uses gts_pkg and the shared assertion macros.
`include "gillespie_two_species_step_core_macros.svh"
module gts_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [gts_pkg::TIME_W-1:0]     sim_time,
    input logic [gts_pkg::COUNT_BITS-1:0] count_a,
    input logic [2:0]                     fired,
    input logic                           extinct
);
    import gts_pkg::*;

    `GTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(count_a) && $stable(sim_time) && $stable(fired))
    `GTS_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
    `GTS_ASSERT_NOW(a_fired_range, out_valid, fired <= RX_A_GROW)
    `GTS_ASSERT_NOW(a_extinct_none, out_valid && extinct, fired == FIRED_NONE)
endmodule

bind gillespie_two_species_step_core gts_checker u_gts_checker (.*);
